// File: hdl/kcl_pkg.sv
// kcl_pkg: shared types, codes and constants of the keypad code lock
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int KCL_CODE_DIGITS = 6;

    // operation codes carried by an input item
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_IGNORED = 4'd0,
        ST_DIGIT   = 4'd1,
        ST_ARMED   = 4'd2,
        ST_CHANGED = 4'd3,
        ST_OPENED  = 4'd4,
        ST_ALREADY = 4'd5,
        ST_WRONG   = 4'd6,
        ST_CLEARED = 4'd7,
        ST_CLOSED  = 4'd8
    } t_status;

    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_EQUAL = 8'h3D;
    localparam logic [7:0] KEY_CHG   = 8'h63;
    localparam logic [7:0] KEY_RST   = 8'h72;

    localparam logic [1:0] SERVO_CLOSED = 2'd1;
    localparam logic [1:0] SERVO_OPEN   = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_code;
        logic       long_press;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic       door_is_open;
        logic [1:0] servo_position;
        logic       change_pending;
        logic [2:0] digits_entered;
    } t_result;

endpackage

// File: hdl/kcl_in_reg.sv
// kcl_in_reg: input register stage holding one accepted key or remote item
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  kcl_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_ready,
    output logic          o_valid,
    output kcl_pkg::t_item o_item
);
    import kcl_pkg::*;

    logic  r_valid;
    t_item r_item;

    // free slot, or the held item leaves in this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_valid && o_ready) || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/kcl_engine.sv
// kcl_engine: lock state (code, entry, modes, door) and the per-item decision logic
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_engine #(
    parameter int CODE_DIGITS = kcl_pkg::KCL_CODE_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  kcl_pkg::t_item   i_item,
    output kcl_pkg::t_result o_result
);
    import kcl_pkg::*;

    localparam int CW = $clog2(CODE_DIGITS + 1);

    logic [3:0]    r_code  [CODE_DIGITS];
    logic [3:0]    n_code  [CODE_DIGITS];
    logic [3:0]    r_entry [CODE_DIGITS];
    logic [3:0]    n_entry [CODE_DIGITS];
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_change, n_change;
    logic          r_door, n_door;
    logic          r_latch, n_latch;

    logic          is_digit;
    logic [3:0]    digit_val;
    logic          match;
    t_status       status;

    assign is_digit  = (i_item.key_code >= KEY_ZERO) && (i_item.key_code <= KEY_NINE);
    assign digit_val = 4'(i_item.key_code - KEY_ZERO);

    // entry equals code in length and in every held digit
    always_comb begin
        match = (r_count == r_len);
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if ((CW'(i) < r_count) && (r_entry[i] != r_code[i])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        n_code   = r_code;
        n_entry  = r_entry;
        n_len    = r_len;
        n_count  = r_count;
        n_change = r_change;
        n_door   = r_door;
        n_latch  = r_latch;
        status   = ST_IGNORED;

        unique case (i_item.op)
            OP_KEY: begin
                n_latch = r_latch | i_item.long_press;
                priority if (is_digit) begin
                    if (r_count < CW'(CODE_DIGITS)) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (r_count == CW'(i)) begin
                                n_entry[i] = digit_val;
                            end
                        end
                        n_count = r_count + 1'b1;
                        status  = ST_DIGIT;
                    end
                end else if (i_item.key_code == KEY_EQUAL) begin
                    if (r_change) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (CW'(i) < r_count) begin
                                n_code[i] = r_entry[i];
                            end
                        end
                        n_len    = r_count;
                        n_change = 1'b0;
                        status   = ST_CHANGED;
                    end else if (match) begin
                        status = r_door ? ST_ALREADY : ST_OPENED;
                        n_door = 1'b1;
                    end else begin
                        status = ST_WRONG;
                    end
                    n_count = '0;
                end else if (i_item.key_code == KEY_CHG) begin
                    n_change = 1'b1;
                    status   = ST_ARMED;
                end else if (i_item.key_code == KEY_RST) begin
                    // code reset needs a latched long press; entry count stays
                    if (n_latch) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            n_code[i]  = 4'd0;
                            n_entry[i] = 4'd0;
                        end
                        n_len   = CW'(CODE_DIGITS);
                        n_latch = 1'b0;
                        status  = ST_CLEARED;
                    end
                end else begin
                    // unknown key
                    status = ST_IGNORED;
                end
            end
            OP_OPEN: begin
                n_door = 1'b1;
                status = ST_OPENED;
            end
            OP_CLOSE: begin
                n_door = 1'b0;
                status = ST_CLOSED;
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase

        o_result.status         = status;
        o_result.door_is_open   = n_door;
        o_result.servo_position = n_door ? SERVO_OPEN : SERVO_CLOSED;
        o_result.change_pending = n_change;
        o_result.digits_entered = 3'(n_count);
    end

    for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_code
        localparam logic [3:0] RST_DIGIT = 4'((g + 1) % 10);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_code[g] <= RST_DIGIT;
            end else if (i_fire) begin
                r_code[g] <= n_code[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= CW'(CODE_DIGITS);
            r_count  <= '0;
            r_change <= 1'b0;
            r_door   <= 1'b0;
            r_latch  <= 1'b0;
        end else if (i_fire) begin
            r_len    <= n_len;
            r_count  <= n_count;
            r_change <= n_change;
            r_door   <= n_door;
            r_latch  <= n_latch;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(CODE_DIGITS)) && (r_len <= CW'(CODE_DIGITS)))
        else $error("entry count or code length beyond digit capacity");

    a_equal_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.op == OP_KEY) && (i_item.key_code == KEY_EQUAL))
        |=> (r_count == '0))
        else $error("entry not cleared after end of entry");

    a_digit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.op == OP_KEY) && is_digit && (r_count < CW'(CODE_DIGITS)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("digit taken without count advance");

    a_close_shuts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.op == OP_CLOSE)) |=> !r_door)
        else $error("door still open after remote close");

    a_reset_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (o_result.status == ST_CLEARED)) |=> (!r_latch && (r_len == CW'(CODE_DIGITS))))
        else $error("code reset left latch set or wrong length");
`endif

endmodule

// File: hdl/kcl_out_reg.sv
// kcl_out_reg: result register toward the receiver, frees itself when the item is taken
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kcl_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output kcl_pkg::t_result o_result
);
    import kcl_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hdl/keypad_code_lock_top.sv
// Keypad code lock. Input channel i_valid/o_ready carries one event per item:
// i_op 0 is a key press (i_key_code ASCII, i_long_press held-long flag),
// 1 a remote open, 2 a remote close. Output channel o_valid/i_ready returns
// exactly one result item per event: status code, door flag, servo position,
// change-pending flag and number of digits held in the entry.
// An accepted event sits in the input register while the decision logic feeds
// the result register, which loads the result once it is free.
// Throughput: one event per cycle while the receiver takes results; the
// whole decision (six-digit compare or copy) is combinational between the
// two registers.
// Reset (synchronous, i_rst_n low): code 1 2 3 4 5 6 of full length, entry
// empty, change mode off, door closed, long-press latch clear, both channels
// empty. The block is ready as soon as reset is released.
// When the receiver stalls the result register holds; one more event waits
// in the input register, after which o_ready drops until i_ready returns.
// Depends on kcl_pkg, kcl_in_reg, kcl_engine and kcl_out_reg.
`timescale 1ns / 1ps

module keypad_code_lock_top #(
    parameter int CODE_DIGITS = kcl_pkg::KCL_CODE_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_key_code,
    input  logic       i_long_press,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_status,
    output logic       o_door_is_open,
    output logic [1:0] o_servo_position,
    output logic       o_change_pending,
    output logic [2:0] o_digits_entered
);
    import kcl_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    fire;
    t_result next_result;
    t_result out_result;

    assign in_item.op         = i_op;
    assign in_item.key_code   = i_key_code;
    assign in_item.long_press = i_long_press;

    // the held item is processed when the result register can take its result
    assign fire = held_valid && out_free;

    kcl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (fire),
        .o_ready (o_ready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    kcl_engine #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (next_result)
    );

    kcl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (next_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_status         = out_result.status;
    assign o_door_is_open   = out_result.door_is_open;
    assign o_servo_position = out_result.servo_position;
    assign o_change_pending = out_result.change_pending;
    assign o_digits_entered = out_result.digits_entered;

endmodule
